### rtl/core/lfo_pkg.sv
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared types, register indexes and the triangle table for the LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_pkg;

  localparam int unsigned PhaseW   = 32;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned RandW    = 32;
  localparam int unsigned SampleW  = 7;
  localparam int unsigned RawW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAVE_SEL  = 2'd1;

  typedef enum logic [1:0] {
    WAVE_TRI   = 2'd0,
    WAVE_SAW   = 2'd1,
    WAVE_SQR   = 2'd2,
    WAVE_NOISE = 2'd3
  } wave_e;

  // one item in flight between the input register and the result register
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    wave_e            wave;
    logic [RandW-1:0] rnd;
  } lfo_item_t;

  // triangle ramp scaled by 127/64, round half to even
  function automatic logic signed [RawW-1:0] tri_entry(input logic [IdxW-1:0] i);
    int n;
    int a;
    int q;
    int r;
    int res;
    if (int'(i) <= 64) begin
      n = int'(i);
    end else if (int'(i) <= 192) begin
      n = 128 - int'(i);
    end else begin
      n = int'(i) - 256;
    end
    a = ((n < 0) ? -n : n) * 127;
    q = a / 64;
    r = a % 64;
    if (r > 32 || (r == 32 && (q % 2) == 1)) begin
      q = q + 1;
    end
    res = (n < 0) ? -q : q;
    return RawW'(res);
  endfunction

endpackage

`default_nettype wire

### rtl/core/lfo_phase_acc.sv
// ----------------------------------------------------------------------------
// lfo_phase_acc
// Configuration registers and the 32-bit phase accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_phase_acc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lfo_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          step_i,
  input  wire logic                          restart_i,
  output lfo_pkg::wave_e                     wave_o,
  output logic [lfo_pkg::IdxW-1:0]           idx_o
);
  import lfo_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] inc_q;
  wave_e             wave_q;
  logic [PhaseW-1:0] phase_cur;

  // restart clears the phase used for this transfer
  assign phase_cur = restart_i ? '0 : phase_q;
  assign phase_d   = phase_cur + inc_q;
  assign idx_o     = phase_cur[PhaseW-1 -: IdxW];
  assign wave_o    = wave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      inc_q   <= '0;
      wave_q  <= WAVE_TRI;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PHASE_INC: inc_q  <= cfg_wdata_i[PhaseW-1:0];
          CFG_WAVE_SEL:  wave_q <= wave_e'(cfg_wdata_i[1:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/lfo_shaper.sv
// ----------------------------------------------------------------------------
// lfo_shaper
// Turns a phase index, wave code and random word into a halved sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_shaper (
  input  wire lfo_pkg::lfo_item_t              item_i,
  output logic signed [lfo_pkg::SampleW-1:0]   sample_o
);
  import lfo_pkg::*;

  logic [IdxW-1:0]          j;
  logic signed [RawW:0]     saw;
  logic [9:0]               byte_sum;
  logic [8:0]               fold;
  logic [7:0]               rmod;
  logic signed [RawW:0]     noise;
  logic signed [RawW-1:0]   raw;
  logic signed [RawW-1:0]   rounded;
  logic signed [RawW-1:0]   halved;

  // saw: (255-idx)*254/255 equals j-1 for j>0 and 0 for j=0
  assign j   = ~item_i.idx;
  assign saw = (j == '0) ? -9'sd127 : ($signed({1'b0, j}) - 9'sd128);

  // mod 255 by byte folding, since 256 is 1 mod 255
  assign byte_sum = {2'b0, item_i.rnd[7:0]}   + {2'b0, item_i.rnd[15:8]}
                  + {2'b0, item_i.rnd[23:16]} + {2'b0, item_i.rnd[31:24]};
  assign fold  = {7'b0, byte_sum[9:8]} + {1'b0, byte_sum[7:0]};
  assign rmod  = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
  assign noise = $signed({1'b0, rmod}) - 9'sd127;

  always_comb begin
    case (item_i.wave)
      WAVE_TRI:   raw = tri_entry(item_i.idx);
      WAVE_SAW:   raw = saw[RawW-1:0];
      WAVE_SQR:   raw = item_i.idx[IdxW-1] ? 8'sd127 : 8'sd0;
      WAVE_NOISE: raw = noise[RawW-1:0];
      default:    raw = '0;
    endcase
  end

  // halve toward zero
  assign rounded  = raw + $signed({{(RawW-1){1'b0}}, raw[RawW-1]});
  assign halved   = rounded >>> 1;
  assign sample_o = halved[SampleW-1:0];

endmodule

`default_nettype wire

### rtl/core/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Phase-accumulator LFO: triangle, saw, square and noise waves.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake               | Payload
// input    | in        | in_valid_i / in_stall_o  | restart_i, random_word_i
// result   | out       | out_valid_o / out_stall_i| sample_o
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One transfer per cycle sustained while the result is not stalled; a sample
// passes through the input register, then the result register, to the outputs.
// The phase advances at the input transfer; the wave logic sits between the
// two registers. Reset clears phase, increment, wave select and valids.
// A stalled result holds; the input register keeps taking transfers until
// both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_waveform_generator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lfo_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [lfo_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               restart_i,
  input  wire logic [lfo_pkg::RandW-1:0]          random_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [lfo_pkg::SampleW-1:0]      sample_o
);
  import lfo_pkg::*;

  logic                        in_xfer;
  logic                        out_ready;
  logic                        s1_ready;
  logic                        s1_valid_q;
  lfo_item_t                   s1_q, s1_d;
  logic                        s2_valid_q;
  logic signed [SampleW-1:0]   s2_q, s2_d;
  wave_e                       wave;
  logic [IdxW-1:0]             idx;

  assign out_ready  = !s2_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && s1_ready;

  lfo_phase_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (in_xfer),
    .restart_i   (restart_i),
    .wave_o      (wave),
    .idx_o       (idx)
  );

  assign s1_d.idx  = idx;
  assign s1_d.wave = wave;
  assign s1_d.rnd  = random_word_i;

  lfo_shaper u_shp (
    .item_i   (s1_q),
    .sample_o (s2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
    if (out_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign sample_o    = s2_q;

endmodule

`default_nettype wire

### rtl/core/lfo_checker.sv
// ----------------------------------------------------------------------------
// lfo_checker
// Port-level checks for the LFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [lfo_pkg::SampleW-1:0] sample_o
);
  import lfo_pkg::*;

  // a held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample changed");

  // halving never yields the most negative code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o != -7'sd64)
    else $error("sample out of range");

  // input backpressure only when the result side is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

  // a result leaves only through a transfer
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o)
);

`default_nettype wire
